// File: rtl/core/ttl_pkg.sv
// ----------------------------------------------------------------------------
// ttl_pkg
// Types and constants shared by the text token lexer modules.
// ----------------------------------------------------------------------------
package ttl_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int LINE_BITS   = 20;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int OBUF_DEPTH   = 4;
    localparam int OBUF_PTR_W   = $clog2(OBUF_DEPTH);
    localparam int OBUF_CNT_W   = $clog2(OBUF_DEPTH + 1);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_IDENT   = 3'd3,
        MODE_NUMBER  = 3'd4,
        MODE_QUOTED  = 3'd5,
        MODE_UNKNOWN = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        KIND_EOF     = 3'd0,
        KIND_IDENT   = 3'd1,
        KIND_QUOTED  = 3'd2,
        KIND_INT     = 3'd3,
        KIND_FLOAT   = 3'd4,
        KIND_PUNCT   = 3'd5,
        KIND_UNKNOWN = 3'd6
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_end;
    } t_in_item;

    typedef struct packed {
        t_kind                  token_kind;
        logic [7:0]             punct_char;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [OFFSET_BITS-1:0] token_length;
        logic [LINE_BITS-1:0]   line_number;
        logic                   space_before;
        logic                   newline_before;
        logic                   last_of_run;
    } t_out_item;

    typedef struct packed {
        logic blank;
        logic space;
        logic newline;
        logic slash;
        logic ident_start;
        logic digit;
        logic letter_e;
        logic dot;
        logic num_start;
        logic quote;
        logic punct;
    } t_class;

    typedef struct packed {
        t_in_item item;
        t_class   cls;
    } t_q_item;

endpackage

// File: rtl/core/text_token_lexer.sv
// ----------------------------------------------------------------------------
// text_token_lexer
// Streaming text lexer taking one byte per item and giving token items.
// ----------------------------------------------------------------------------
// Accepts one byte per cycle while the item queue is not full; an item's
// results pass first through the item queue, then through the output buffer.
// A byte that ends a token and is itself punctuation, or the end marker after
// an open token, gives two items; the output side then sets the pace.
// Synchronous active-low reset empties both queues and returns to line 0.
module text_token_lexer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ttl_pkg::t_in_item  i_in_item,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output ttl_pkg::t_out_item o_out_item,
    input  logic               i_out_ready
);

    logic             w_push;
    ttl_pkg::t_q_item w_push_item;
    logic             w_full;
    logic             w_pop;
    logic             w_empty;
    ttl_pkg::t_q_item w_head;

    ttl_front u_front (
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .o_in_ready   (o_in_ready),
        .o_push       (w_push),
        .o_push_item  (w_push_item),
        .i_queue_full (w_full)
    );

    ttl_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_empty     (w_empty),
        .o_head      (w_head)
    );

    ttl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_ready (i_out_ready)
    );

endmodule

// File: rtl/core/ttl_front.sv
// ----------------------------------------------------------------------------
// ttl_front
// Accepts input items and classifies each byte for the lexer back end.
// ----------------------------------------------------------------------------
module ttl_front (
    input  logic              i_in_valid,
    input  ttl_pkg::t_in_item i_in_item,
    output logic              o_in_ready,
    output logic              o_push,
    output ttl_pkg::t_q_item  o_push_item,
    input  logic              i_queue_full
);

    logic [7:0]      w_b;
    ttl_pkg::t_class w_cls;

    assign w_b = i_in_item.in_byte;

    always_comb begin
        w_cls             = '0;
        w_cls.blank       = (w_b == ttl_pkg::CH_SPACE) || (w_b == ttl_pkg::CH_TAB) ||
                            (w_b == ttl_pkg::CH_CR);
        w_cls.space       = (w_b == ttl_pkg::CH_SPACE);
        w_cls.newline     = (w_b == ttl_pkg::CH_NL);
        w_cls.slash       = (w_b == ttl_pkg::CH_SLASH);
        w_cls.ident_start = ((w_b >= 8'h61) && (w_b <= 8'h7A)) ||
                            ((w_b >= 8'h41) && (w_b <= 8'h5A)) ||
                            (w_b == ttl_pkg::CH_UNDER);
        w_cls.digit       = (w_b >= 8'h30) && (w_b <= 8'h39);
        w_cls.letter_e    = (w_b == ttl_pkg::CH_E);
        w_cls.dot         = (w_b == ttl_pkg::CH_DOT);
        w_cls.num_start   = w_cls.digit || (w_b == ttl_pkg::CH_DOT) ||
                            (w_b == ttl_pkg::CH_MINUS);
        w_cls.quote       = (w_b == ttl_pkg::CH_QUOTE);
        case (w_b)
            8'h7B, 8'h7D, 8'h28, 8'h29, ttl_pkg::CH_HASH, 8'h3A, 8'h27, 8'h3D, 8'h2C,
            8'h5B, 8'h5D: begin
                w_cls.punct = 1'b1;
            end
            default: begin
                w_cls.punct = 1'b0;
            end
        endcase
    end

    assign o_in_ready       = !i_queue_full;
    assign o_push           = i_in_valid && !i_queue_full;
    assign o_push_item.item = i_in_item;
    assign o_push_item.cls  = w_cls;

endmodule

// File: rtl/core/ttl_queue.sv
// ----------------------------------------------------------------------------
// ttl_queue
// Short queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module ttl_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ttl_pkg::t_q_item i_push_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output ttl_pkg::t_q_item o_head
);

    ttl_pkg::t_q_item                  r_mem [ttl_pkg::QUEUE_DEPTH];
    logic [ttl_pkg::QUEUE_PTR_W-1:0]   r_wr;
    logic [ttl_pkg::QUEUE_PTR_W-1:0]   r_rd;
    logic [ttl_pkg::QUEUE_CNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == ttl_pkg::QUEUE_CNT_W'(ttl_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + ttl_pkg::QUEUE_CNT_W'(i_push) - ttl_pkg::QUEUE_CNT_W'(i_pop);
        end
    end

endmodule

// File: rtl/core/ttl_back.sv
// ----------------------------------------------------------------------------
// ttl_back
// Lexer state machine and output buffer: one classified item per cycle while the buffer has room for its results.
// ----------------------------------------------------------------------------
module ttl_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  ttl_pkg::t_q_item   i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    output ttl_pkg::t_out_item o_out_item,
    input  logic               i_out_ready
);

    localparam int OW = ttl_pkg::OFFSET_BITS;
    localparam int LW = ttl_pkg::LINE_BITS;

    ttl_pkg::t_mode r_mode, n_mode;
    logic [OW-1:0]  r_pos, n_pos;
    logic [LW-1:0]  r_line, n_line;
    logic [OW-1:0]  r_start, n_start;
    logic [1:0]     r_flags, n_flags;
    logic           r_seen, n_seen;
    logic           r_take, n_take;

    ttl_pkg::t_out_item              r_buf [ttl_pkg::OBUF_DEPTH];
    logic [ttl_pkg::OBUF_PTR_W-1:0]  r_wr;
    logic [ttl_pkg::OBUF_PTR_W-1:0]  r_rd;
    logic [ttl_pkg::OBUF_CNT_W-1:0]  r_cnt;

    logic           w_end;
    logic [7:0]     w_b;
    ttl_pkg::t_class w_c;
    logic           w_open_emit;
    logic           w_do_idle;
    logic           w_second;
    logic           w_ident_cont;
    logic           w_num_cont;
    logic [OW-1:0]  w_pos_inc;
    logic [OW-1:0]  w_open_len;
    ttl_pkg::t_out_item w_tok0, w_tok1;
    ttl_pkg::t_out_item w_slot_a, w_slot_b;
    logic           w_push_a, w_push_b;
    logic           w_out_pop;

    assign w_end     = i_head.item.is_end;
    assign w_b       = i_head.item.in_byte;
    assign w_c       = i_head.cls;
    assign o_pop     = !i_empty && (r_cnt <= ttl_pkg::OBUF_CNT_W'(ttl_pkg::OBUF_DEPTH - 2));
    assign w_pos_inc = (r_pos == ttl_pkg::OFF_MAX) ? r_pos : r_pos + 1'b1;
    assign w_open_len = (r_pos >= r_start) ? r_pos - r_start : '0;
    assign w_ident_cont = w_c.ident_start || w_c.digit;
    assign w_num_cont   = w_c.digit || w_c.letter_e || (w_c.dot && !r_seen);

    always_comb begin
        w_open_emit = 1'b0;
        w_do_idle   = 1'b0;
        case (r_mode)
            ttl_pkg::MODE_SLASH: begin
                w_open_emit = w_end || !w_c.slash;
                w_do_idle   = !w_end && !w_c.slash;
            end
            ttl_pkg::MODE_COMMENT: begin
                w_do_idle = !w_end && w_c.newline;
            end
            ttl_pkg::MODE_IDENT: begin
                w_open_emit = w_end || !w_ident_cont;
                w_do_idle   = !w_end && !w_ident_cont;
            end
            ttl_pkg::MODE_NUMBER: begin
                w_open_emit = w_end || (!r_take && !w_num_cont);
                w_do_idle   = !w_end && !r_take && !w_num_cont;
            end
            ttl_pkg::MODE_QUOTED: begin
                w_open_emit = w_end || w_c.quote;
            end
            ttl_pkg::MODE_UNKNOWN: begin
                w_open_emit = w_end || w_c.space || w_c.newline;
                w_do_idle   = !w_end && (w_c.space || w_c.newline);
            end
            default: begin
                w_do_idle = !w_end;
            end
        endcase
        w_second = w_end || (w_do_idle && w_c.punct);
    end

    // Next state.
    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_line  = r_line;
        n_start = r_start;
        n_flags = r_flags;
        n_seen  = r_seen;
        n_take  = r_take;
        if (o_pop) begin
            if (w_end) begin
                n_mode  = ttl_pkg::MODE_IDLE;
                n_pos   = '0;
                n_line  = '0;
                n_start = '0;
                n_flags = '0;
                n_seen  = 1'b0;
                n_take  = 1'b0;
            end else begin
                n_pos = w_pos_inc;
                if (w_open_emit) begin
                    n_flags = '0;
                    n_mode  = ttl_pkg::MODE_IDLE;
                end
                if (w_do_idle) begin
                    n_mode = ttl_pkg::MODE_IDLE;
                    if (w_c.blank) begin
                        n_flags[0] = 1'b1;
                    end else if (w_c.newline) begin
                        n_flags[1] = 1'b1;
                        n_line = (r_line == ttl_pkg::LINE_MAX) ? r_line : r_line + 1'b1;
                    end else if (w_c.slash) begin
                        n_mode  = ttl_pkg::MODE_SLASH;
                        n_start = r_pos;
                    end else if (w_c.ident_start) begin
                        n_mode  = ttl_pkg::MODE_IDENT;
                        n_start = r_pos;
                    end else if (w_c.num_start) begin
                        n_mode  = ttl_pkg::MODE_NUMBER;
                        n_start = r_pos;
                        n_seen  = w_c.dot;
                        n_take  = 1'b0;
                    end else if (w_c.quote) begin
                        n_mode  = ttl_pkg::MODE_QUOTED;
                        n_start = w_pos_inc;
                    end else if (w_c.punct) begin
                        n_flags = '0;
                    end else begin
                        n_mode  = ttl_pkg::MODE_UNKNOWN;
                        n_start = r_pos;
                    end
                end else if (!w_open_emit) begin
                    case (r_mode)
                        ttl_pkg::MODE_SLASH: begin
                            n_mode = ttl_pkg::MODE_COMMENT;
                        end
                        ttl_pkg::MODE_NUMBER: begin
                            if (r_take) begin
                                n_take = 1'b0;
                            end else begin
                                if (w_c.dot) begin
                                    n_seen = 1'b1;
                                end
                                if (w_c.letter_e) begin
                                    n_take = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    // Result items.
    always_comb begin
        w_tok0                = '0;
        w_tok0.start_offset   = r_start;
        w_tok0.token_length   = w_open_len;
        w_tok0.line_number    = r_line;
        w_tok0.space_before   = r_flags[0];
        w_tok0.newline_before = r_flags[1];
        case (r_mode)
            ttl_pkg::MODE_SLASH: begin
                w_tok0.token_kind   = ttl_pkg::KIND_PUNCT;
                w_tok0.punct_char   = ttl_pkg::CH_SLASH;
                w_tok0.token_length = OW'(1);
            end
            ttl_pkg::MODE_IDENT: begin
                w_tok0.token_kind = ttl_pkg::KIND_IDENT;
            end
            ttl_pkg::MODE_NUMBER: begin
                w_tok0.token_kind = r_seen ? ttl_pkg::KIND_FLOAT : ttl_pkg::KIND_INT;
            end
            ttl_pkg::MODE_QUOTED: begin
                w_tok0.token_kind = ttl_pkg::KIND_QUOTED;
            end
            default: begin
                w_tok0.token_kind = ttl_pkg::KIND_UNKNOWN;
            end
        endcase

        w_tok1                = '0;
        w_tok1.start_offset   = r_pos;
        w_tok1.line_number    = r_line;
        w_tok1.space_before   = w_open_emit ? 1'b0 : r_flags[0];
        w_tok1.newline_before = w_open_emit ? 1'b0 : r_flags[1];
        w_tok1.last_of_run    = 1'b1;
        if (w_end) begin
            w_tok1.token_kind   = ttl_pkg::KIND_EOF;
            w_tok1.punct_char   = ttl_pkg::CH_NUL;
            w_tok1.token_length = '0;
        end else begin
            w_tok1.token_kind   = ttl_pkg::KIND_PUNCT;
            w_tok1.punct_char   = w_b;
            w_tok1.token_length = OW'(1);
        end
        w_tok0.last_of_run = !w_second;

        w_slot_a = w_open_emit ? w_tok0 : w_tok1;
        w_slot_b = w_tok1;
        w_push_a = o_pop && (w_open_emit || w_second);
        w_push_b = o_pop && w_open_emit && w_second;
    end

    assign o_out_valid = (r_cnt != '0);
    assign o_out_item  = r_buf[r_rd];
    assign w_out_pop   = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (w_push_a) begin
            r_buf[r_wr] <= w_slot_a;
        end
        if (w_push_b) begin
            r_buf[r_wr + ttl_pkg::OBUF_PTR_W'(1)] <= w_slot_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ttl_pkg::MODE_IDLE;
            r_pos   <= '0;
            r_line  <= '0;
            r_start <= '0;
            r_flags <= '0;
            r_seen  <= 1'b0;
            r_take  <= 1'b0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_start <= n_start;
            r_flags <= n_flags;
            r_seen  <= n_seen;
            r_take  <= n_take;
            r_wr    <= r_wr + ttl_pkg::OBUF_PTR_W'(w_push_a) + ttl_pkg::OBUF_PTR_W'(w_push_b);
            if (w_out_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + ttl_pkg::OBUF_CNT_W'(w_push_a) + ttl_pkg::OBUF_CNT_W'(w_push_b)
                     - ttl_pkg::OBUF_CNT_W'(w_out_pop);
        end
    end

    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ttl_pkg::OBUF_CNT_W'(ttl_pkg::OBUF_DEPTH))
        else $error("output buffer count out of range");

    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_cnt <= ttl_pkg::OBUF_CNT_W'(ttl_pkg::OBUF_DEPTH - 2)))
        else $error("item taken without room for its results");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_end) |=> (r_pos == '0 && r_mode == ttl_pkg::MODE_IDLE && r_flags == '0))
        else $error("end of buffer did not return the lexer to its start");

    a_end_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_end) |-> (w_push_a && w_slot_b.token_kind == ttl_pkg::KIND_EOF))
        else $error("end of buffer without an EOF item");

endmodule

// File: verif/text_token_lexer_tb.sv
// ----------------------------------------------------------------------------
// text_token_lexer_tb
// Self-checking bench for the streaming text lexer. A short table of hand
// picked bytes comes first, then randomly built text buffers: mostly well
// formed tokens with random content, some raw noise. A behavioural lexer
// inside the bench predicts the items of each untyped row; a typed row
// carries its own expected item. Both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module text_token_lexer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttl_pkg::*;

    localparam int RANDOM_ITEMS = 1550;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PERCENT = 10;

    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] PUNCT_SET [12] = '{
        8'h7B, 8'h7D, 8'h28, 8'h29, CH_HASH, 8'h3A,
        8'h27, 8'h3D, 8'h2C, 8'h5B, 8'h5D, CH_SLASH
    };

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item token;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    t_in_item  in_item;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;
    logic      out_ready;

    t_row      stim[$];
    t_row      directed_rows [27];
    t_out_item tokens_due[$];
    t_out_item step_out[$];

    int errors;
    int taken;
    int checked;
    int cycles;
    int buffers;
    int kinds_seen [8];

    t_mode                  lx_mode     = MODE_IDLE;
    logic [OFFSET_BITS-1:0] lx_pos      = '0;
    logic [OFFSET_BITS-1:0] lx_start    = '0;
    logic [LINE_BITS-1:0]   lx_line     = '0;
    logic                   lx_space    = 1'b0;
    logic                   lx_newline  = 1'b0;
    logic                   lx_dot_seen = 1'b0;
    logic                   lx_take_any = 1'b0;

    text_token_lexer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_ready (out_ready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= CH_LOW_A && b <= CH_LOW_Z) || (b >= CH_UP_A && b <= CH_UP_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_letter(b) || is_digit(b) || b == CH_UNDER;
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        foreach (PUNCT_SET[k]) begin
            if (PUNCT_SET[k] != CH_SLASH && PUNCT_SET[k] == b) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic starts_token(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_NL ||
               b == CH_SLASH || b == CH_QUOTE || b == CH_DOT || b == CH_MINUS ||
               is_word(b) || is_punct(b);
    endfunction

    function automatic logic [OFFSET_BITS-1:0] bump_pos(input logic [OFFSET_BITS-1:0] v);
        return (v == OFF_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] open_len();
        return (lx_pos >= lx_start) ? lx_pos - lx_start : '0;
    endfunction

    function automatic t_kind number_kind();
        return lx_dot_seen ? KIND_FLOAT : KIND_INT;
    endfunction

    task automatic clear_lexer();
        lx_mode     = MODE_IDLE;
        lx_pos      = '0;
        lx_start    = '0;
        lx_line     = '0;
        lx_space    = 1'b0;
        lx_newline  = 1'b0;
        lx_dot_seen = 1'b0;
        lx_take_any = 1'b0;
    endtask

    task automatic emit_token(input t_kind kind, input logic [7:0] ch,
                              input logic [OFFSET_BITS-1:0] start,
                              input logic [OFFSET_BITS-1:0] len);
        t_out_item tok;
        tok.token_kind     = kind;
        tok.punct_char     = ch;
        tok.start_offset   = start;
        tok.token_length   = len;
        tok.line_number    = lx_line;
        tok.space_before   = lx_space;
        tok.newline_before = lx_newline;
        tok.last_of_run    = 1'b0;
        if (step_out.size() < 2) begin
            step_out.push_back(tok);
            lx_space   = 1'b0;
            lx_newline = 1'b0;
            lx_mode    = MODE_IDLE;
        end
    endtask

    task automatic between_tokens(input logic [7:0] b);
        lx_mode = MODE_IDLE;
        if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
            lx_space = 1'b1;
        end else if (b == CH_NL) begin
            lx_newline = 1'b1;
            if (lx_line != LINE_MAX) begin
                lx_line = lx_line + 1'b1;
            end
        end else if (b == CH_SLASH) begin
            lx_mode  = MODE_SLASH;
            lx_start = lx_pos;
        end else if (is_letter(b) || b == CH_UNDER) begin
            lx_mode  = MODE_IDENT;
            lx_start = lx_pos;
        end else if (is_digit(b) || b == CH_DOT || b == CH_MINUS) begin
            lx_mode     = MODE_NUMBER;
            lx_start    = lx_pos;
            lx_dot_seen = (b == CH_DOT);
            lx_take_any = 1'b0;
        end else if (b == CH_QUOTE) begin
            lx_mode  = MODE_QUOTED;
            lx_start = bump_pos(lx_pos);
        end else if (is_punct(b)) begin
            emit_token(KIND_PUNCT, b, lx_pos, OFFSET_BITS'(1));
        end else begin
            lx_mode  = MODE_UNKNOWN;
            lx_start = lx_pos;
        end
        lx_pos = bump_pos(lx_pos);
    endtask

    task automatic predict_tokens(input t_in_item it);
        logic [7:0] b;
        t_out_item  tail;
        b = it.in_byte;
        step_out.delete();
        if (it.is_end) begin
            case (lx_mode)
                MODE_SLASH:   emit_token(KIND_PUNCT, CH_SLASH, lx_start, OFFSET_BITS'(1));
                MODE_IDENT:   emit_token(KIND_IDENT, CH_NUL, lx_start, open_len());
                MODE_NUMBER:  emit_token(number_kind(), CH_NUL, lx_start, open_len());
                MODE_QUOTED:  emit_token(KIND_QUOTED, CH_NUL, lx_start, open_len());
                MODE_UNKNOWN: emit_token(KIND_UNKNOWN, CH_NUL, lx_start, open_len());
                default: ;
            endcase
            emit_token(KIND_EOF, CH_NUL, lx_pos, '0);
            clear_lexer();
        end else begin
            case (lx_mode)
                MODE_SLASH: begin
                    if (b == CH_SLASH) begin
                        lx_mode = MODE_COMMENT;
                        lx_pos  = bump_pos(lx_pos);
                    end else begin
                        emit_token(KIND_PUNCT, CH_SLASH, lx_start, OFFSET_BITS'(1));
                        between_tokens(b);
                    end
                end
                MODE_COMMENT: begin
                    if (b == CH_NL) begin
                        between_tokens(b);
                    end else begin
                        lx_pos = bump_pos(lx_pos);
                    end
                end
                MODE_IDENT: begin
                    if (is_word(b)) begin
                        lx_pos = bump_pos(lx_pos);
                    end else begin
                        emit_token(KIND_IDENT, CH_NUL, lx_start, open_len());
                        between_tokens(b);
                    end
                end
                MODE_NUMBER: begin
                    if (lx_take_any) begin
                        lx_take_any = 1'b0;
                        lx_pos      = bump_pos(lx_pos);
                    end else if (is_digit(b) || b == CH_E || (b == CH_DOT && !lx_dot_seen)) begin
                        if (b == CH_DOT) begin
                            lx_dot_seen = 1'b1;
                        end
                        if (b == CH_E) begin
                            lx_take_any = 1'b1;
                        end
                        lx_pos = bump_pos(lx_pos);
                    end else begin
                        emit_token(number_kind(), CH_NUL, lx_start, open_len());
                        between_tokens(b);
                    end
                end
                MODE_QUOTED: begin
                    if (b == CH_QUOTE) begin
                        emit_token(KIND_QUOTED, CH_NUL, lx_start, open_len());
                    end
                    lx_pos = bump_pos(lx_pos);
                end
                MODE_UNKNOWN: begin
                    if (b == CH_SPACE || b == CH_NL) begin
                        emit_token(KIND_UNKNOWN, CH_NUL, lx_start, open_len());
                        between_tokens(b);
                    end else begin
                        lx_pos = bump_pos(lx_pos);
                    end
                end
                default: between_tokens(b);
            endcase
        end
        if (step_out.size() > 0) begin
            tail = step_out.pop_back();
            tail.last_of_run = 1'b1;
            step_out.push_back(tail);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    task automatic field_check(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("token %0d %s got 0x%0h want 0x%0h",
                                      checked, name, got, want));
        end
    endtask

    task automatic check_token(input t_out_item got, input t_out_item want);
        field_check("token_kind", 32'(got.token_kind), 32'(want.token_kind));
        field_check("punct_char", 32'(got.punct_char), 32'(want.punct_char));
        field_check("start_offset", 32'(got.start_offset), 32'(want.start_offset));
        field_check("token_length", 32'(got.token_length), 32'(want.token_length));
        field_check("line_number", 32'(got.line_number), 32'(want.line_number));
        field_check("space_before", 32'(got.space_before), 32'(want.space_before));
        field_check("newline_before", 32'(got.newline_before), 32'(want.newline_before));
        field_check("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
    endtask

    function automatic t_row byte_row(input logic [7:0] b);
        t_row r;
        r = '0;
        r.item.in_byte = b;
        return r;
    endfunction

    function automatic t_row end_row(input logic [7:0] b);
        t_row r;
        r = byte_row(b);
        r.item.is_end = 1'b1;
        return r;
    endfunction

    function automatic t_row typed_row(input t_row r, input t_kind kind, input logic [7:0] ch,
                                       input int start, input int len, input int line,
                                       input logic sp, input logic nl);
        r.typed                = 1'b1;
        r.token.token_kind     = kind;
        r.token.punct_char     = ch;
        r.token.start_offset   = OFFSET_BITS'(start);
        r.token.token_length   = OFFSET_BITS'(len);
        r.token.line_number    = LINE_BITS'(line);
        r.token.space_before   = sp;
        r.token.newline_before = nl;
        r.token.last_of_run    = 1'b1;
        return r;
    endfunction

    function automatic logic [7:0] pick_letter();
        return $urandom_range(0, 1) ? 8'(CH_LOW_A + $urandom_range(0, 25))
                                    : 8'(CH_UP_A + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_NL;
        endcase
    endfunction

    function automatic logic [7:0] pick_word_char();
        case ($urandom_range(0, 3))
            0:       return pick_digit();
            1:       return CH_UNDER;
            default: return pick_letter();
        endcase
    endfunction

    function automatic logic [7:0] pick_number_char();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            return pick_digit();
        end
        return (sel < 8) ? CH_DOT : CH_E;
    endfunction

    task automatic add_byte(input logic [7:0] b);
        stim.push_back(byte_row(b));
    endtask

    task automatic add_piece();
        int         sel;
        int         n;
        logic [7:0] b;
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            n = $urandom_range(1, 3);
            repeat (n) add_byte(pick_blank());
        end else if (sel < 30) begin
            add_byte(($urandom_range(0, 4) == 0) ? CH_UNDER : pick_letter());
            n = $urandom_range(0, 6);
            repeat (n) add_byte(pick_word_char());
        end else if (sel < 45) begin
            case ($urandom_range(0, 3))
                0:       add_byte(CH_DOT);
                1:       add_byte(CH_MINUS);
                default: add_byte(pick_digit());
            endcase
            n = $urandom_range(0, 6);
            repeat (n) begin
                b = pick_number_char();
                add_byte(b);
                if (b == CH_E) begin
                    add_byte(8'($urandom_range(0, 255)));
                end
            end
        end else if (sel < 55) begin
            add_byte(CH_QUOTE);
            n = $urandom_range(0, 5);
            repeat (n) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
                add_byte(b);
            end
            if ($urandom_range(0, 9) != 0) begin
                add_byte(CH_QUOTE);
            end
        end else if (sel < 72) begin
            add_byte(PUNCT_SET[$urandom_range(0, 11)]);
        end else if (sel < 80) begin
            add_byte(CH_SLASH);
            add_byte(CH_SLASH);
            n = $urandom_range(0, 8);
            repeat (n) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
                add_byte(b);
            end
            if ($urandom_range(0, 4) != 0) begin
                add_byte(CH_NL);
            end
        end else if (sel < 90) begin
            do b = 8'($urandom_range(0, 255)); while (starts_token(b));
            add_byte(b);
            n = $urandom_range(0, 4);
            repeat (n) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_SPACE || b == CH_NL);
                add_byte(b);
            end
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_stimulus();
        int n;
        directed_rows = '{
            typed_row(end_row(8'hFF), KIND_EOF, CH_NUL, 0, 0, 0, 1'b0, 1'b0),
            typed_row(byte_row(8'h7B), KIND_PUNCT, 8'h7B, 0, 1, 0, 1'b0, 1'b0),
            byte_row(CH_SPACE),
            byte_row(CH_UNDER),
            byte_row(CH_NINE),
            byte_row(8'h28),
            byte_row(CH_NL),
            byte_row(CH_SLASH),
            byte_row(8'h3A),
            byte_row(8'h37),
            byte_row(CH_E),
            byte_row(8'hFF),
            byte_row(CH_CR),
            byte_row(CH_SLASH),
            byte_row(CH_SLASH),
            byte_row(CH_NL),
            byte_row(CH_DOT),
            byte_row(8'h35),
            byte_row(CH_DOT),
            byte_row(CH_QUOTE),
            byte_row(CH_NUL),
            byte_row(CH_QUOTE),
            byte_row(8'h80),
            byte_row(CH_SPACE),
            byte_row(CH_SLASH),
            byte_row(CH_SLASH),
            typed_row(end_row(8'h00), KIND_EOF, CH_NUL, 25, 0, 2, 1'b1, 1'b0)
        };
        foreach (directed_rows[k]) begin
            stim.push_back(directed_rows[k]);
        end
        while (stim.size() < $size(directed_rows) + RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 20);
                repeat (n) add_byte(8'($urandom_range(0, 255)));
            end else begin
                n = $urandom_range(1, 10);
                repeat (n) begin
                    add_piece();
                    if ($urandom_range(0, 1) != 0) begin
                        add_byte(pick_blank());
                    end
                end
            end
            stim.push_back(end_row(8'($urandom_range(0, 255))));
            buffers++;
        end
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d tokens outstanding.",
                     cycles, tokens_due.size());
            $display("text_token_lexer_tb NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_out_item want;
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                predict_tokens(in_item);
                if (stim[taken].typed) begin
                    tokens_due.push_back(stim[taken].token);
                end else begin
                    foreach (step_out[k]) begin
                        tokens_due.push_back(step_out[k]);
                    end
                end
                taken++;
            end
            if (out_valid && out_ready) begin
                kinds_seen[out_item.token_kind]++;
                if (tokens_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected token item, kind %0d offset %0d",
                                              out_item.token_kind, out_item.start_offset));
                end else begin
                    want = tokens_due.pop_front();
                    check_token(out_item, want);
                end
                checked++;
            end
        end
    end

    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ready = i_rst_n &&
                        ((cycles >= 600 && cycles < 1100) ||
                         $urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    initial begin
        int   sent;
        logic moved;
        in_valid = 1'b0;
        in_item  = '0;
        i_rst_n  = 1'b0;
        build_stimulus();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        sent  = 0;
        moved = 1'b0;
        while (sent < stim.size()) begin
            @(negedge i_clk);
            if (!in_valid || moved) begin
                if ((sent >= 900 && sent < 1200) || $urandom_range(0, 99) >= IDLE_PERCENT) begin
                    in_valid = 1'b1;
                    in_item  = stim[sent].item;
                end else begin
                    in_valid = 1'b0;
                end
            end
            moved = 1'b0;
            @(posedge i_clk);
            if (in_valid && in_ready) begin
                moved = 1'b1;
                sent++;
            end
        end
        @(negedge i_clk);
        in_valid = 1'b0;

        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Fed %0d bytes and end markers over %0d random buffers; checked %0d tokens.",
                 stim.size(), buffers, checked);
        $display("Tokens by kind: eof %0d ident %0d quoted %0d int %0d float %0d",
                 kinds_seen[KIND_EOF], kinds_seen[KIND_IDENT], kinds_seen[KIND_QUOTED],
                 kinds_seen[KIND_INT], kinds_seen[KIND_FLOAT]);
        $display("  punct %0d unknown %0d; %0d mismatches.",
                 kinds_seen[KIND_PUNCT], kinds_seen[KIND_UNKNOWN], errors);
        if (errors == 0) begin
            $display("text_token_lexer_tb OK");
        end else begin
            $display("text_token_lexer_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/ttl_pkg.sv
rtl/core/ttl_front.sv
rtl/core/ttl_queue.sv
rtl/core/ttl_back.sv
rtl/core/text_token_lexer.sv
verif/text_token_lexer_tb.sv
